// ----- hw/rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// types and codes shared by the circular deque and its storage cells
// ----------------------------------------------------------------------------
package cdq_pkg;

    // operation codes on the func field
    localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_REAR   = 2'd2;
    localparam logic [1:0] OP_POP_FRONT  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 6;

    // input beat
    typedef struct packed {
        logic [1:0]               func;
        logic signed [WORD_W-1:0] push_value;
    } cdq_in_t;

    // result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } cdq_out_t;

    // command broadcast to every cell, at most one strobe high
    typedef struct packed {
        logic                     push_rear;
        logic                     push_front;
        logic                     pop_rear;
        logic                     pop_front;
        logic signed [WORD_W-1:0] word;
    } cdq_cmd_t;

    // return chain stage carrying a word popped at the rear
    typedef struct packed {
        logic                     valid;
        logic signed [WORD_W-1:0] word;
    } cdq_ret_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cdq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell
// one storage cell of the deque chain with its return chain stage
// ----------------------------------------------------------------------------
module cdq_cell (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cdq_pkg::cdq_cmd_t                 cmd,
    input  wire logic                              prev_valid,
    input  wire logic signed [cdq_pkg::WORD_W-1:0] prev_word,
    input  wire logic                              next_valid,
    input  wire logic signed [cdq_pkg::WORD_W-1:0] next_word,
    input  wire cdq_pkg::cdq_ret_t                 ret_in,
    output logic                                   valid,
    output logic signed [cdq_pkg::WORD_W-1:0]      word,
    output cdq_pkg::cdq_ret_t                      ret_out
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [cdq_pkg::WORD_W-1:0] word_reg;
    logic signed [cdq_pkg::WORD_W-1:0] word_next;
    cdq_pkg::cdq_ret_t                 ret_reg;
    cdq_pkg::cdq_ret_t                 ret_next;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        ret_next   = ret_in;
        priority if (cmd.push_front) begin
            // whole row moves one place towards the rear
            valid_next = prev_valid;
            word_next  = prev_word;
        end else if (cmd.push_rear) begin
            // first empty cell takes the word
            if (prev_valid && !valid_reg) begin
                valid_next = 1'b1;
                word_next  = cmd.word;
            end
        end else if (cmd.pop_front) begin
            // whole row moves one place towards the front
            valid_next = next_valid;
            word_next  = next_word;
        end else if (cmd.pop_rear) begin
            // last occupied cell empties and launches its word down the chain
            if (valid_reg && !next_valid) begin
                valid_next     = 1'b0;
                ret_next.valid = 1'b1;
                ret_next.word  = word_reg;
            end
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            ret_reg.valid <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            ret_reg.valid <= ret_next.valid;
        end
        word_reg     <= word_next;
        ret_reg.word <= ret_next.word;
    end

    assign valid   = valid_reg;
    assign word    = word_reg;
    assign ret_out = ret_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/circular_deque.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of signed 32-bit words held in a row of storage cells
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_data carry one operation per beat: push rear, push
//   front, pop rear or pop front; push_value is ignored on pops
//   m_valid/m_ready/m_data return exactly one result beat per operation:
//   popped word (zero unless a pop succeeded), status and occupancy after it
//   the words sit packed in cell 0 (front) upwards; push front and pop front
//   shift the whole row together, push rear fills the first free cell
//   push, pop front and any rejection give the result in the cycle after
//   acceptance, so one beat per cycle while the sink keeps up
//   pop rear launches the rear word down a return chain that moves one cell
//   per cycle; its result is registered once the word reaches cell 0, and
//   no new beat is taken until then
//   a full push or an empty pop is rejected with the state untouched
//   a waiting result does not block the next beat if m_ready is high in the
//   same cycle; while m_ready stays low the result holds and s_ready drops
//   reset (aresetn low, synchronous) empties the deque at once; word
//   contents are not cleared
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cdq_pkg::cdq_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cdq_pkg::cdq_out_t      m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_WAIT_RET
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    cdq_pkg::cdq_out_t                 m_data_reg;
    cdq_pkg::cdq_out_t                 m_data_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;

    // cell row wiring
    logic [DEPTH-1:0]                  cell_valid;
    logic signed [cdq_pkg::WORD_W-1:0] cell_word [DEPTH];
    cdq_pkg::cdq_ret_t                 ret_chain [DEPTH];
    cdq_pkg::cdq_cmd_t                 cmd;

    logic accept;
    logic is_push;
    logic full;
    logic empty;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_push = (s_data.func == cdq_pkg::OP_PUSH_REAR) ||
                     (s_data.func == cdq_pkg::OP_PUSH_FRONT);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // command broadcast, only legal operations reach the cells
    always_comb begin
        cmd            = '0;
        cmd.word       = s_data.push_value;
        cmd.push_rear  = accept && (s_data.func == cdq_pkg::OP_PUSH_REAR) && !full;
        cmd.push_front = accept && (s_data.func == cdq_pkg::OP_PUSH_FRONT) && !full;
        cmd.pop_rear   = accept && (s_data.func == cdq_pkg::OP_POP_REAR) && !empty;
        cmd.pop_front  = accept && (s_data.func == cdq_pkg::OP_POP_FRONT) && !empty;
    end

    // row of cells, cell 0 holds the front word
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic                              prev_valid;
            logic signed [cdq_pkg::WORD_W-1:0] prev_word;
            logic                              next_valid;
            logic signed [cdq_pkg::WORD_W-1:0] next_word;
            cdq_pkg::cdq_ret_t                 ret_in;

            if (i == 0) begin : g_front
                // the front push enters here and the empty-push-rear lands here
                assign prev_valid = 1'b1;
                assign prev_word  = s_data.push_value;
            end else begin : g_inner_prev
                assign prev_valid = cell_valid[i-1];
                assign prev_word  = cell_word[i-1];
            end

            if (i == DEPTH - 1) begin : g_rear
                assign next_valid = 1'b0;
                assign next_word  = '0;
                assign ret_in     = '0;
            end else begin : g_inner_next
                assign next_valid = cell_valid[i+1];
                assign next_word  = cell_word[i+1];
                assign ret_in     = ret_chain[i+1];
            end

            cdq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .prev_valid (prev_valid),
                .prev_word  (prev_word),
                .next_valid (next_valid),
                .next_word  (next_word),
                .ret_in     (ret_in),
                .valid      (cell_valid[i]),
                .word       (cell_word[i]),
                .ret_out    (ret_chain[i])
            );
        end
    endgenerate

    // sequencing and result register
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        count_next   = count_reg;

        // result beat taken by the sink
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_data_next.pop_value = '0;
                    m_data_next.status    = cdq_pkg::ST_DONE;
                    if (is_push) begin
                        if (full) begin
                            m_data_next.status = cdq_pkg::ST_FULL;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                        m_valid_next = 1'b1;
                    end else if (empty) begin
                        m_data_next.status = cdq_pkg::ST_EMPTY;
                        m_valid_next       = 1'b1;
                    end else begin
                        count_next = count_reg - 1'b1;
                        if (s_data.func == cdq_pkg::OP_POP_REAR) begin
                            // rear word arrives later through the return chain
                            state_next = ST_WAIT_RET;
                        end else begin
                            m_data_next.pop_value = cell_word[0];
                            m_valid_next          = 1'b1;
                        end
                    end
                    m_data_next.occupancy = cdq_pkg::OCC_W'(count_next);
                end
            end
            ST_WAIT_RET: begin
                // result slot is free here: it was emptied when the pop was taken
                if (ret_chain[0].valid) begin
                    m_data_next.pop_value = ret_chain[0].word;
                    m_data_next.status    = cdq_pkg::ST_DONE;
                    m_data_next.occupancy = cdq_pkg::OCC_W'(count_reg);
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    logic [DEPTH-1:0] ret_valid_vec;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_ret_vec
            assign ret_valid_vec[i] = ret_chain[i].valid;
        end
    endgenerate

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy counter beyond depth");

    a_count_match : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with occupancy counter");

    a_packed_row : assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid + 1'b1) & cell_valid) == '0)
        else $error("occupied cells not packed from the front");

    a_one_return : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ret_valid_vec))
        else $error("more than one word on the return chain");

    a_return_when_waiting : assert property (@(posedge aclk) disable iff (!aresetn)
        ret_chain[0].valid |-> (state_reg == ST_WAIT_RET) && !m_valid_reg)
        else $error("return word arrived outside a rear pop");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for circular_deque: a queue-fed driver offers push and
// pop beats with random gaps, a monitor with random stalls compares every
// result beat against a behavioural deque kept alongside the block
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH          = 32;
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int N_ITEMS        = 950;
    localparam int HOLD_AT        = 400;    // result count at which the sink holds off
    localparam int HOLD_LEN       = 150;    // length of that hold-off in cycles
    localparam int FAST_FIRST     = 390;    // items sent without gaps around the hold-off
    localparam int FAST_LAST      = 470;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // one queued operation with its pre-drawn gap and an optional drain pause
    typedef struct {
        cdq_pkg::cdq_in_t beat;
        int unsigned      gap;
        bit               drain;
    } op_item_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    cdq_pkg::cdq_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    cdq_pkg::cdq_out_t m_data;

    op_item_t          pending_ops[$];
    cdq_pkg::cdq_out_t awaited_results[$];
    int unsigned n_queued  = 0;
    int unsigned gap_mode  = 0;
    int unsigned beats_in  = 0;     // operation beats accepted by the block
    int unsigned beats_out = 0;     // result beats taken from the block
    int unsigned gap_cnt   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned fails       = 0;

    // behavioural deque: circular store, end pointers and word count
    logic signed [cdq_pkg::WORD_W-1:0] deque_words [DEPTH];
    logic [PTR_W-1:0]                  front_ptr  = '0;
    logic [PTR_W-1:0]                  rear_ptr   = '0;
    logic [PTR_W:0]                    word_count = '0;

    // coverage tallies for the closing summary
    int unsigned n_push_ok = 0;
    int unsigned n_pop_ok  = 0;
    int unsigned n_full    = 0;
    int unsigned n_empty   = 0;
    int unsigned peak_occ  = 0;

    circular_deque #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // deque behaviour: applies one operation and returns the result beat
    // ------------------------------------------------------------------------
    function automatic cdq_pkg::cdq_out_t apply_op(input cdq_pkg::cdq_in_t op);
        cdq_pkg::cdq_out_t res;
        res        = '0;
        res.status = cdq_pkg::ST_DONE;
        case (op.func)
            cdq_pkg::OP_PUSH_REAR, cdq_pkg::OP_PUSH_FRONT: begin
                if (word_count == DEPTH) begin
                    res.status = cdq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    if (word_count == 0) begin
                        // first word always lands in entry zero, whichever end
                        front_ptr      = '0;
                        rear_ptr       = '0;
                        deque_words[0] = op.push_value;
                    end else if (op.func == cdq_pkg::OP_PUSH_REAR) begin
                        rear_ptr = (rear_ptr == PTR_W'(DEPTH - 1)) ?
                                   '0 : rear_ptr + 1'b1;
                        deque_words[rear_ptr] = op.push_value;
                    end else begin
                        front_ptr = (front_ptr == '0) ?
                                    PTR_W'(DEPTH - 1) : front_ptr - 1'b1;
                        deque_words[front_ptr] = op.push_value;
                    end
                    word_count++;
                    n_push_ok++;
                end
            end
            cdq_pkg::OP_POP_REAR, cdq_pkg::OP_POP_FRONT: begin
                if (word_count == 0) begin
                    res.status = cdq_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    if (op.func == cdq_pkg::OP_POP_REAR) begin
                        res.pop_value = deque_words[rear_ptr];
                        rear_ptr = (rear_ptr == '0) ?
                                   PTR_W'(DEPTH - 1) : rear_ptr - 1'b1;
                    end else begin
                        res.pop_value = deque_words[front_ptr];
                        front_ptr = (front_ptr == PTR_W'(DEPTH - 1)) ?
                                    '0 : front_ptr + 1'b1;
                    end
                    word_count--;
                    // emptied: both ends go back to entry zero
                    if (word_count == 0) begin
                        front_ptr = '0;
                        rear_ptr  = '0;
                    end
                    n_pop_ok++;
                end
            end
        endcase
        res.occupancy = cdq_pkg::OCC_W'(word_count);
        if (word_count > peak_occ)
            peak_occ = word_count;
        return res;
    endfunction

    // word mix biased towards the extremes and small values
    function automatic logic signed [cdq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return cdq_pkg::WORD_W'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // queue one operation; gap drawn by the current mode, fast window forced to zero
    task automatic add_op(input logic [1:0] func,
                          input logic signed [cdq_pkg::WORD_W-1:0] word);
        op_item_t item;
        item.beat.func       = func;
        item.beat.push_value = word;
        if (n_queued >= FAST_FIRST && n_queued <= FAST_LAST)
            item.gap = 0;
        else if (gap_mode == 0)
            item.gap = 0;
        else if (gap_mode == 1)
            item.gap = $urandom_range(0, 15);
        else
            item.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
        // twice in the run the sender waits until every result is back
        item.drain = (n_queued == 300 || n_queued == 700);
        pending_ops.push_back(item);
        n_queued++;
    endtask

    // compare one result beat with the oldest outstanding expectation
    task automatic check_result(input cdq_pkg::cdq_out_t got);
        cdq_pkg::cdq_out_t want;
        if (awaited_results.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("ERROR: result beat with nothing outstanding: %s %0d %s %0d %s %0d",
                         "value", got.pop_value, "status", got.status,
                         "occ", got.occupancy);
            return;
        end
        want = awaited_results.pop_front();
        if (got.pop_value !== want.pop_value || got.status !== want.status ||
            got.occupancy !== want.occupancy) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("ERROR: result %0d: value %0d/%0d status %0d/%0d %s %0d/%0d",
                         beats_out, want.pop_value, got.pop_value, want.status,
                         got.status, "occ (exp/got)", want.occupancy, got.occupancy);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: takes items off the pending queue, honours gaps and drain pauses
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic        offer;
        int unsigned taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            gap_cnt <= 0;
        end else begin
            offer = s_valid;
            taken = beats_in;
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_op(s_data));
                taken    = beats_in + 1;
                beats_in <= taken;
                offer    = 1'b0;
            end
            if (!offer && pending_ops.size() != 0) begin
                if (gap_cnt < pending_ops[0].gap) begin
                    gap_cnt <= gap_cnt + 1;
                end else if (!pending_ops[0].drain || beats_out == taken) begin
                    // drain pause: only launch once every result is home
                    s_data  <= pending_ops[0].beat;
                    offer   = 1'b1;
                    gap_cnt <= 0;
                    void'(pending_ops.pop_front());
                end
            end
            // single assignment per edge keeps valid steady across back-to-back beats
            s_valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random per-beat stalls, quiet stretches, and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic        rdy;
        int unsigned pause;
        bit          quiet;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            rdy   = m_ready;
            quiet = ((beats_out / 64) % 4 == 1);
            if (m_valid && m_ready) begin
                check_result(m_data);
                beats_out <= beats_out + 1;
                pause = quiet ? 0 : $urandom_range(0, 15);
                if (beats_out + 1 == HOLD_AT && !hold_done) begin
                    // long hold-off: the block fills its output and stalls input
                    hold_left <= HOLD_LEN;
                    hold_done <= 1'b1;
                    rdy       = 1'b0;
                end else if (pause != 0) begin
                    stall_left <= pause;
                    rdy        = 1'b0;
                end
            end else if (!m_ready) begin
                if (hold_left != 0)
                    hold_left <= hold_left - 1;
                else if (stall_left != 0)
                    stall_left <= stall_left - 1;
                else
                    rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    // watchdog on cycles in which neither channel moves a beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no beat accepted for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned kind;
        int unsigned len;
        int unsigned push_pct;
        bit          is_push;

        // directed opening from reset: empty pops, single-word round trips at
        // both ends, front wrap below entry zero, extreme and patterned words
        gap_mode = 1;
        add_op(cdq_pkg::OP_POP_REAR,   $urandom);
        add_op(cdq_pkg::OP_POP_FRONT,  $urandom);
        add_op(cdq_pkg::OP_PUSH_REAR,  32'sh7FFF_FFFF);
        add_op(cdq_pkg::OP_POP_REAR,   $urandom);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        add_op(cdq_pkg::OP_POP_FRONT,  $urandom);
        gap_mode = 0;
        add_op(cdq_pkg::OP_PUSH_FRONT, -32'sd1);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'sd0);
        add_op(cdq_pkg::OP_PUSH_REAR,  32'sh5555_5555);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
        add_op(cdq_pkg::OP_POP_FRONT,  $urandom);
        add_op(cdq_pkg::OP_POP_REAR,   $urandom);
        add_op(cdq_pkg::OP_POP_REAR,   $urandom);
        add_op(cdq_pkg::OP_POP_FRONT,  $urandom);
        add_op(cdq_pkg::OP_PUSH_REAR,  32'sd1);
        add_op(cdq_pkg::OP_PUSH_REAR,  32'sd2);
        add_op(cdq_pkg::OP_POP_FRONT,  $urandom);
        add_op(cdq_pkg::OP_POP_FRONT,  $urandom);

        // from empty: overfill then overdrain, hitting full and empty at both ends
        gap_mode = 2;
        repeat (DEPTH + 2)
            add_op($urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT,
                   pick_word());
        repeat (DEPTH + 2)
            add_op($urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT,
                   $urandom);

        // random bursts: filling, draining and mixed, each with its own gap style
        while (n_queued < N_ITEMS) begin
            kind     = $urandom_range(0, 9);
            len      = $urandom_range(10, 45);
            gap_mode = $urandom_range(0, 2);
            push_pct = (kind <= 2) ? 85 : (kind <= 5) ? 15 : 50;
            repeat (len) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                if (is_push)
                    add_op($urandom_range(0, 1) ?
                           cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT, pick_word());
                else
                    add_op($urandom_range(0, 1) ?
                           cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT, $urandom);
            end
        end

        // reset held low from the start, then released at an edge
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_in < n_queued || beats_out < n_queued)
            @(posedge aclk);
        // a rear pop can take up to a full row's walk; watch for strays
        repeat (DEPTH + 8) @(posedge aclk);

        if (awaited_results.size() != 0) begin
            fails += awaited_results.size();
            $display("ERROR: %0d results never arrived", awaited_results.size());
        end

        $display("%0d operations: %0d pushes, %0d pops, %0d full and %0d empty rejections",
                 beats_in, n_push_ok, n_pop_ok, n_full, n_empty);
        $display("peak occupancy %0d of %0d, %0d result beats checked, %0d failures",
                 peak_occ, DEPTH, beats_out, fails);
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
